// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the rate limiter RTL.
// Included by name; no other dependencies. Clock is always "clock", reset is "reset".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/pktb_pkg.sv -----
// Package for the per-key token bucket limiter: widths, codes, table entry layout
// and the djb2 hash helper. No dependencies.
package pktb_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;

   localparam int unsigned KEY_W      = 64;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned TOK_W      = 16;
   localparam int unsigned PERIOD_W   = 20;
   localparam int unsigned ACTION_W   = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned HASH_W     = 32;

   localparam logic [HASH_W-1:0] DJB2_SEED  = 32'd5381;
   localparam int unsigned       DJB2_SHIFT = 5;

   // request classes
   localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LIST     = 2'd2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_REG_MAX    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LKP_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LKP_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LST_MAX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LST_PERIOD = 3'd5;

   // register reset values
   localparam logic [TOK_W-1:0]    RST_REG_MAX    = 16'd10;
   localparam logic [PERIOD_W-1:0] RST_REG_PERIOD = 20'd3600;
   localparam logic [TOK_W-1:0]    RST_LKP_MAX    = 16'd100;
   localparam logic [PERIOD_W-1:0] RST_LKP_PERIOD = 20'd60;
   localparam logic [TOK_W-1:0]    RST_LST_MAX    = 16'd100;
   localparam logic [PERIOD_W-1:0] RST_LST_PERIOD = 20'd60;

   // one table row
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  tag_hi;
      logic [KEY_W-1:0]  tag_lo;
      logic [TIME_W-1:0] last_time;
      logic [TOK_W-1:0]  tok_reg;
      logic [TOK_W-1:0]  tok_lkp;
      logic [TOK_W-1:0]  tok_lst;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // djb2 over the eight bytes of a word, most significant byte first
   function automatic logic [HASH_W-1:0] djb2_word(input logic [HASH_W-1:0] seed,
                                                   input logic [KEY_W-1:0]  word);
      logic [HASH_W-1:0] h;
      h = seed;
      for (int i = 0; i < 8; i++) begin
         h = (h << DJB2_SHIFT) + h + {24'd0, word[KEY_W-1-8*i -: 8]};
      end
      return h;
   endfunction

endpackage

// ----- hdl/pktb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pktb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ----- hdl/per_key_token_bucket_limiter_top.sv -----
// Per-key token bucket limiter: hashed direct-mapped table in one RAM plus sequencer.
// Depends on pktb_pkg, pktb_ram and assert_macros.svh.
// Sequence: with a key, an accepted request steps through HASH0, HASH1, RAM read,
// evaluate and commit/write back, then rsp_valid strobes from a register; without a
// key it goes from HASH0 straight to commit. No new request is taken until idle again.
// Reset: synchronous; afterwards busy stays high while the table is swept clear one
// row a cycle. Configuration writes are taken at any time.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module per_key_token_bucket_limiter_top #(
   parameter int unsigned TABLE_DEPTH = pktb_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [pktb_pkg::ACTION_W-1:0]       req_action,
   input  logic                                req_key_present,
   input  logic [pktb_pkg::KEY_W-1:0]          req_key_high,
   input  logic [pktb_pkg::KEY_W-1:0]          req_key_low,
   input  logic [pktb_pkg::TIME_W-1:0]         req_now_secs,
   // response
   output logic                                rsp_valid,
   output logic                                rsp_allowed,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pktb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pktb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH0  = 3'd2;
   localparam logic [2:0] ST_HASH1  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_EVAL   = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   // captured request
   logic [pktb_pkg::ACTION_W-1:0] action_ff;
   logic                          present_ff;
   logic [pktb_pkg::KEY_W-1:0]    key_high_ff;
   logic [pktb_pkg::KEY_W-1:0]    key_low_ff;
   logic [pktb_pkg::TIME_W-1:0]   now_ff;

   logic [pktb_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   pktb_pkg::entry_type         work_ff, work_in;

   // configuration registers
   logic [pktb_pkg::TOK_W-1:0]    reg_max_ff, lkp_max_ff, lst_max_ff;
   logic [pktb_pkg::PERIOD_W-1:0] reg_per_ff, lkp_per_ff, lst_per_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_allowed_ff, rsp_allowed_in;

   logic                         ram_we, ram_re;
   logic [IDX_W-1:0]             ram_waddr;
   logic [pktb_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   pktb_pkg::entry_type          rd_entry, base_entry, wr_entry;
   logic                         hit, advance, req_fire;
   logic [pktb_pkg::TIME_W-1:0]  elapsed;

   assign busy        = (state_ff != ST_IDLE);
   assign req_fire    = start && !busy;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = rsp_allowed_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_max_ff <= pktb_pkg::RST_REG_MAX;
         reg_per_ff <= pktb_pkg::RST_REG_PERIOD;
         lkp_max_ff <= pktb_pkg::RST_LKP_MAX;
         lkp_per_ff <= pktb_pkg::RST_LKP_PERIOD;
         lst_max_ff <= pktb_pkg::RST_LST_MAX;
         lst_per_ff <= pktb_pkg::RST_LST_PERIOD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pktb_pkg::CSR_REG_MAX:    reg_max_ff <= csr_wdata[pktb_pkg::TOK_W-1:0];
            pktb_pkg::CSR_REG_PERIOD: reg_per_ff <= csr_wdata;
            pktb_pkg::CSR_LKP_MAX:    lkp_max_ff <= csr_wdata[pktb_pkg::TOK_W-1:0];
            pktb_pkg::CSR_LKP_PERIOD: lkp_per_ff <= csr_wdata;
            pktb_pkg::CSR_LST_MAX:    lst_max_ff <= csr_wdata[pktb_pkg::TOK_W-1:0];
            pktb_pkg::CSR_LST_PERIOD: lst_per_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff   <= req_action;
         present_ff  <= req_key_present;
         key_high_ff <= req_key_high;
         key_low_ff  <= req_key_low;
         now_ff      <= req_now_secs;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == {IDX_W{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE:   if (start) state_in = ST_HASH0;
         ST_HASH0:  state_in = present_ff ? ST_HASH1 : ST_COMMIT;
         ST_HASH1:  state_in = ST_READ;
         ST_READ:   state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // hash: eight bytes per cycle, index is the low bits
   assign hash_in = pktb_pkg::djb2_word(pktb_pkg::DJB2_SEED, key_high_ff);
   assign idx_in  = IDX_W'(pktb_pkg::djb2_word(hash_ff, key_low_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_HASH0) hash_ff <= hash_in;
      if (state_ff == ST_HASH1) idx_ff  <= idx_in;
   end

   // evaluate: tag check, replace on miss, refill on elapsed periods
   assign rd_entry = pktb_pkg::entry_type'(ram_rdata);
   assign hit      = rd_entry.valid && (rd_entry.tag_hi == key_high_ff)
                     && (rd_entry.tag_lo == key_low_ff);

   always_comb begin
      if (hit) begin
         base_entry = rd_entry;
      end else begin
         base_entry.valid     = 1'b1;
         base_entry.tag_hi    = key_high_ff;
         base_entry.tag_lo    = key_low_ff;
         base_entry.last_time = now_ff;
         base_entry.tok_reg   = reg_max_ff;
         base_entry.tok_lkp   = lkp_max_ff;
         base_entry.tok_lst   = lst_max_ff;
      end
      advance = now_ff > base_entry.last_time;
      elapsed = now_ff - base_entry.last_time;
      work_in = base_entry;
      if (advance) begin
         if (elapsed >= pktb_pkg::TIME_W'(reg_per_ff)) work_in.tok_reg = reg_max_ff;
         if (elapsed >= pktb_pkg::TIME_W'(lkp_per_ff)) work_in.tok_lkp = lkp_max_ff;
         if (elapsed >= pktb_pkg::TIME_W'(lst_per_ff)) work_in.tok_lst = lst_max_ff;
         work_in.last_time = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) work_ff <= work_in;
   end

   // commit: take one token of the requested class if one is left
   always_comb begin
      wr_entry       = work_ff;
      rsp_allowed_in = 1'b0;
      unique case (action_ff)
         pktb_pkg::ACT_REGISTER: if (work_ff.tok_reg != '0) begin
            wr_entry.tok_reg = work_ff.tok_reg - 1'b1;
            rsp_allowed_in   = 1'b1;
         end
         pktb_pkg::ACT_LOOKUP: if (work_ff.tok_lkp != '0) begin
            wr_entry.tok_lkp = work_ff.tok_lkp - 1'b1;
            rsp_allowed_in   = 1'b1;
         end
         pktb_pkg::ACT_LIST: if (work_ff.tok_lst != '0) begin
            wr_entry.tok_lst = work_ff.tok_lst - 1'b1;
            rsp_allowed_in   = 1'b1;
         end
         default: ;
      endcase
      if (!present_ff) rsp_allowed_in = 1'b0;
   end

   assign rsp_valid_in = (state_ff == ST_COMMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_allowed_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         rsp_allowed_ff <= rsp_valid_in && rsp_allowed_in;
      end
   end

   // table memory: clear sweep after reset, write back on commit
   assign ram_re    = (state_ff == ST_READ);
   assign ram_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_COMMIT) && present_ff);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : idx_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : pktb_pkg::ENTRY_W'(wr_entry);

   pktb_ram #(
      .WIDTH (pktb_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // checks
   `ASSERT_SAME(a_we_src, ram_we, (state_ff == ST_CLEAR) || (state_ff == ST_COMMIT), "table write outside clear or commit")
   `ASSERT_SAME(a_commit_valid, (state_ff == ST_COMMIT) && present_ff, ram_we && wr_entry.valid, "commit did not write a valid row")
   `ASSERT_SAME(a_allow_strobe, !rsp_valid, !rsp_allowed, "allowed set without a response beat")
   `ASSERT_NEXT(a_accept_busy, req_fire, busy && !rsp_valid, "accepted beat did not hold busy")
   `ASSERT_NEXT(a_clear_done, (state_ff == ST_CLEAR) && (clr_cnt_ff == {IDX_W{1'b1}}), state_ff == ST_IDLE, "clear sweep did not end")

endmodule

// ----- sim/per_key_token_bucket_limiter_top_test.sv -----
// Self-checking testbench for per_key_token_bucket_limiter_top: directed and random
// requests against a built-in bucket table predictor, with idle gaps and register phases.
// Depends on pktb_pkg and the limiter RTL only.
module per_key_token_bucket_limiter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH           = pktb_pkg::TABLE_DEPTH_DEF;
   localparam int unsigned POOL_SIZE       = 6;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned ITEMS_PER_PHASE = 255;
   localparam int unsigned STALL_LIMIT     = 6000;
   localparam int unsigned SETTLE_CYCLES   = 10;

   // class code that takes no token
   localparam logic [pktb_pkg::ACTION_W-1:0]  ACT_NONE     = 2'd3;
   // register index with nothing behind it
   localparam logic [pktb_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [pktb_pkg::ACTION_W-1:0]   req_action = '0;
   logic                            req_key_present = 1'b0;
   logic [pktb_pkg::KEY_W-1:0]      req_key_high = '0;
   logic [pktb_pkg::KEY_W-1:0]      req_key_low = '0;
   logic [pktb_pkg::TIME_W-1:0]     req_now_secs = '0;
   logic                            rsp_valid;
   logic                            rsp_allowed;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pktb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pktb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   per_key_token_bucket_limiter_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key_present (req_key_present),
      .req_key_high    (req_key_high),
      .req_key_low     (req_key_low),
      .req_now_secs    (req_now_secs),
      .rsp_valid       (rsp_valid),
      .rsp_allowed     (rsp_allowed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state: one bucket row per table slot plus the limit registers
   typedef struct {
      logic                        valid;
      logic [pktb_pkg::KEY_W-1:0]  tag_hi;
      logic [pktb_pkg::KEY_W-1:0]  tag_lo;
      logic [pktb_pkg::TIME_W-1:0] last_time;
      logic [pktb_pkg::TOK_W-1:0]  tok_reg;
      logic [pktb_pkg::TOK_W-1:0]  tok_lkp;
      logic [pktb_pkg::TOK_W-1:0]  tok_lst;
   } bucket_row_type;

   bucket_row_type                bucket_tbl [DEPTH];
   logic [pktb_pkg::TOK_W-1:0]    lim_reg_max, lim_lkp_max, lim_lst_max;
   logic [pktb_pkg::PERIOD_W-1:0] lim_reg_period, lim_lkp_period, lim_lst_period;

   logic                allowed_expected[$];
   logic                want_allowed;
   int unsigned         fail_count = 0;
   int unsigned         stall_cycles = 0;
   int unsigned         idle_pct = 10;

   logic [pktb_pkg::KEY_W-1:0] pool_hi [POOL_SIZE];
   logic [pktb_pkg::KEY_W-1:0] pool_lo [POOL_SIZE];

   // djb2 over the 16 key bytes, high word first, folded to the table depth
   function automatic int unsigned slot_of_key(input logic [pktb_pkg::KEY_W-1:0] hi,
                                               input logic [pktb_pkg::KEY_W-1:0] lo);
      logic [2*pktb_pkg::KEY_W-1:0] key;
      logic [pktb_pkg::HASH_W-1:0]  h;
      key = {hi, lo};
      h   = pktb_pkg::DJB2_SEED;
      for (int i = 0; i < 16; i++)
         h = (h << pktb_pkg::DJB2_SHIFT) + h
             + pktb_pkg::HASH_W'(key[2*pktb_pkg::KEY_W-1-8*i -: 8]);
      return h & (DEPTH - 1);
   endfunction

   function automatic void clear_buckets();
      foreach (bucket_tbl[i]) bucket_tbl[i].valid = 1'b0;
      lim_reg_max    = pktb_pkg::RST_REG_MAX;
      lim_reg_period = pktb_pkg::RST_REG_PERIOD;
      lim_lkp_max    = pktb_pkg::RST_LKP_MAX;
      lim_lkp_period = pktb_pkg::RST_LKP_PERIOD;
      lim_lst_max    = pktb_pkg::RST_LST_MAX;
      lim_lst_period = pktb_pkg::RST_LST_PERIOD;
   endfunction

   function automatic void apply_csr_write(input logic [pktb_pkg::CSR_IDX_W-1:0]  idx,
                                           input logic [pktb_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         pktb_pkg::CSR_REG_MAX:    lim_reg_max    = data[pktb_pkg::TOK_W-1:0];
         pktb_pkg::CSR_REG_PERIOD: lim_reg_period = data[pktb_pkg::PERIOD_W-1:0];
         pktb_pkg::CSR_LKP_MAX:    lim_lkp_max    = data[pktb_pkg::TOK_W-1:0];
         pktb_pkg::CSR_LKP_PERIOD: lim_lkp_period = data[pktb_pkg::PERIOD_W-1:0];
         pktb_pkg::CSR_LST_MAX:    lim_lst_max    = data[pktb_pkg::TOK_W-1:0];
         pktb_pkg::CSR_LST_PERIOD: lim_lst_period = data[pktb_pkg::PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   // allocate/replace, refill on advance of time, then try to take one token
   function automatic logic bucket_predict(input logic [pktb_pkg::ACTION_W-1:0] act,
                                           input logic                          present,
                                           input logic [pktb_pkg::KEY_W-1:0]    hi,
                                           input logic [pktb_pkg::KEY_W-1:0]    lo,
                                           input logic [pktb_pkg::TIME_W-1:0]   ts);
      int unsigned                 slot;
      logic [pktb_pkg::TIME_W-1:0] elapsed;
      logic                        granted;
      granted = 1'b0;
      if (!present) return 1'b0;
      slot = slot_of_key(hi, lo);
      if (!bucket_tbl[slot].valid || bucket_tbl[slot].tag_hi != hi ||
          bucket_tbl[slot].tag_lo != lo) begin
         bucket_tbl[slot].valid     = 1'b1;
         bucket_tbl[slot].tag_hi    = hi;
         bucket_tbl[slot].tag_lo    = lo;
         bucket_tbl[slot].last_time = ts;
         bucket_tbl[slot].tok_reg   = lim_reg_max;
         bucket_tbl[slot].tok_lkp   = lim_lkp_max;
         bucket_tbl[slot].tok_lst   = lim_lst_max;
      end
      if (ts > bucket_tbl[slot].last_time) begin
         elapsed = ts - bucket_tbl[slot].last_time;
         if (elapsed >= pktb_pkg::TIME_W'(lim_reg_period))
            bucket_tbl[slot].tok_reg = lim_reg_max;
         if (elapsed >= pktb_pkg::TIME_W'(lim_lkp_period))
            bucket_tbl[slot].tok_lkp = lim_lkp_max;
         if (elapsed >= pktb_pkg::TIME_W'(lim_lst_period))
            bucket_tbl[slot].tok_lst = lim_lst_max;
         bucket_tbl[slot].last_time = ts;
      end
      case (act)
         pktb_pkg::ACT_REGISTER: if (bucket_tbl[slot].tok_reg != 0) begin
            bucket_tbl[slot].tok_reg--;
            granted = 1'b1;
         end
         pktb_pkg::ACT_LOOKUP: if (bucket_tbl[slot].tok_lkp != 0) begin
            bucket_tbl[slot].tok_lkp--;
            granted = 1'b1;
         end
         pktb_pkg::ACT_LIST: if (bucket_tbl[slot].tok_lst != 0) begin
            bucket_tbl[slot].tok_lst--;
            granted = 1'b1;
         end
         default: ;
      endcase
      return granted;
   endfunction

   // response checker and predictor update, all on sampled pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (allowed_expected.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual allowed=%0b",
                        $time, rsp_allowed);
               fail_count++;
            end else begin
               want_allowed = allowed_expected.pop_front();
               if (rsp_allowed !== want_allowed) begin
                  $display("%0t: allowed mismatch, expected %0b, actual %0b",
                           $time, want_allowed, rsp_allowed);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) apply_csr_write(csr_index, csr_wdata);
         if (start && !busy)
            allowed_expected.push_back(bucket_predict(req_action, req_key_present,
                                                      req_key_high, req_key_low,
                                                      req_now_secs));
      end
   end

   // watchdog: any beat on any channel counts as progress
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one request beat; start stays high afterwards unless the next call idles
   task automatic send_request(input logic [pktb_pkg::ACTION_W-1:0] act,
                               input logic                          present,
                               input logic [pktb_pkg::KEY_W-1:0]    hi,
                               input logic [pktb_pkg::KEY_W-1:0]    lo,
                               input logic [pktb_pkg::TIME_W-1:0]   ts);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_action      <= act;
      req_key_present <= present;
      req_key_high    <= hi;
      req_key_low     <= lo;
      req_now_secs    <= ts;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // csr_valid stays high between writes unless an idle cycle is drawn
   task automatic write_csr(input logic [pktb_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [pktb_pkg::CSR_DATA_W-1:0] data);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_limits(input logic [pktb_pkg::CSR_DATA_W-1:0] reg_max,
                                 input logic [pktb_pkg::CSR_DATA_W-1:0] reg_period,
                                 input logic [pktb_pkg::CSR_DATA_W-1:0] lkp_max,
                                 input logic [pktb_pkg::CSR_DATA_W-1:0] lkp_period,
                                 input logic [pktb_pkg::CSR_DATA_W-1:0] lst_max,
                                 input logic [pktb_pkg::CSR_DATA_W-1:0] lst_period,
                                 input bit                              poke_unmapped);
      if (poke_unmapped) write_csr(CSR_UNMAPPED, pktb_pkg::CSR_DATA_W'($urandom));
      write_csr(pktb_pkg::CSR_REG_MAX, reg_max);
      write_csr(pktb_pkg::CSR_REG_PERIOD, reg_period);
      write_csr(pktb_pkg::CSR_LKP_MAX, lkp_max);
      write_csr(pktb_pkg::CSR_LKP_PERIOD, lkp_period);
      write_csr(pktb_pkg::CSR_LST_MAX, lst_max);
      write_csr(pktb_pkg::CSR_LST_PERIOD, lst_period);
      csr_valid <= 1'b0;
   endtask

   // stop issuing, then wait for every outstanding response and an idle block
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (allowed_expected.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // pairs (0,1) and (2,3) land on the same slot: bump byte 1 of the low word and
   // take 33 off byte 0, which leaves the djb2 sum unchanged
   task automatic build_key_pool();
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_hi[p] = {$urandom, $urandom};
         pool_lo[p] = {$urandom, $urandom};
      end
      for (int p = 0; p < 4; p += 2) begin
         pool_lo[p][7:0]  = 8'($urandom_range(33, 255));
         pool_lo[p][15:8] = 8'($urandom_range(0, 254));
         pool_hi[p+1]     = pool_hi[p];
         pool_lo[p+1]     = pool_lo[p];
         pool_lo[p+1][15:8] = pool_lo[p][15:8] + 8'd1;
         pool_lo[p+1][7:0]  = pool_lo[p][7:0] - 8'd33;
      end
   endtask

   function automatic logic [pktb_pkg::CSR_DATA_W-1:0] random_token_max();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return pktb_pkg::CSR_DATA_W'($urandom);
         default: return {4'($urandom), 16'($urandom_range(1, 4))};
      endcase
   endfunction

   function automatic logic [pktb_pkg::CSR_DATA_W-1:0] random_period();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return pktb_pkg::CSR_DATA_W'($urandom);
         3:       return pktb_pkg::CSR_DATA_W'($urandom_range(7, 120));
         default: return pktb_pkg::CSR_DATA_W'($urandom_range(1, 6));
      endcase
   endfunction

   // mostly standing still, some small forward steps, rare jumps back or anywhere
   function automatic logic [pktb_pkg::TIME_W-1:0] next_time(
      input logic [pktb_pkg::TIME_W-1:0] ts);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60)      return ts;
      else if (r < 85) return ts + $urandom_range(1, 2);
      else if (r < 95) return ts + $urandom_range(3, 20);
      else if (r < 97) return ts + $urandom_range(21, 2000);
      else if (r < 99) return ts - $urandom_range(1, 10);
      else             return $urandom;
   endfunction

   // reset values of the limits: absent keys, first use of a key, every class
   task automatic test_default_limits();
      build_key_pool();
      send_request(pktb_pkg::ACT_REGISTER, 1'b0, {$urandom, $urandom},
                   {$urandom, $urandom}, 32'd1000);
      send_request(pktb_pkg::ACT_LIST, 1'b0, pool_hi[4], pool_lo[4], 32'd1000);
      send_request(pktb_pkg::ACT_REGISTER, 1'b1, pool_hi[4], pool_lo[4], 32'd1000);
      send_request(pktb_pkg::ACT_LOOKUP, 1'b1, pool_hi[4], pool_lo[4], 32'd1000);
      send_request(pktb_pkg::ACT_LIST, 1'b1, pool_hi[4], pool_lo[4], 32'd1000);
      send_request(ACT_NONE, 1'b1, pool_hi[4], pool_lo[4], 32'd1060);
      wait_idle();
   endtask

   // extreme limits: zero period, zero and full token counts, time standing still,
   // going back, key and time extremes, and eviction by a colliding key
   task automatic test_limit_extremes();
      logic [pktb_pkg::KEY_W-1:0] ones;
      ones = '1;
      program_limits(20'hF0001, '0, '0, 20'd1, '1, '1, 1'b1);
      send_request(pktb_pkg::ACT_REGISTER, 1'b1, ones, ones, '0);
      send_request(pktb_pkg::ACT_REGISTER, 1'b1, ones, ones, '0);
      send_request(pktb_pkg::ACT_REGISTER, 1'b1, ones, ones, 32'd1);
      send_request(pktb_pkg::ACT_LOOKUP, 1'b1, ones, ones, 32'd1);
      send_request(pktb_pkg::ACT_LIST, 1'b1, ones, ones, 32'd1);
      send_request(ACT_NONE, 1'b1, ones, ones, 32'd2);
      send_request(pktb_pkg::ACT_REGISTER, 1'b1, ones, ones, 32'd1);
      send_request(pktb_pkg::ACT_LIST, 1'b1, '0, '0, '1);
      send_request(pktb_pkg::ACT_LIST, 1'b1, pool_hi[0], pool_lo[0], 32'd10);
      send_request(pktb_pkg::ACT_LIST, 1'b1, pool_hi[1], pool_lo[1], 32'd10);
      send_request(pktb_pkg::ACT_LIST, 1'b1, pool_hi[0], pool_lo[0], 32'd10);
      wait_idle();
   endtask

   // phases of random limits; most traffic reuses a small key pool so buckets
   // drain, refill and get evicted; the first phase never idles
   task automatic test_random_traffic();
      logic [pktb_pkg::TIME_W-1:0]   ts;
      logic [pktb_pkg::ACTION_W-1:0] act;
      int unsigned                   pick;
      int unsigned                   r;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_pct = (phase == 0) ? 0 : 10;
         program_limits(random_token_max(), random_period(), random_token_max(),
                        random_period(), random_token_max(), random_period(),
                        phase == 3);
         build_key_pool();
         ts = $urandom;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            ts  = next_time(ts);
            act = ($urandom_range(99) < 6) ? ACT_NONE
                                           : pktb_pkg::ACTION_W'($urandom_range(2));
            r   = $urandom_range(99);
            if (r < 4) begin
               send_request(act, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, ts);
            end else if (r < 9) begin
               send_request(act, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, ts);
            end else begin
               pick = $urandom_range(POOL_SIZE - 1);
               send_request(act, 1'b1, pool_hi[pick], pool_lo[pick], ts);
            end
         end
         wait_idle();
      end
   endtask

   initial begin
      clear_buckets();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // table clear sweep after reset
      do @(posedge clock); while (busy);

      test_default_limits();
      test_limit_extremes();
      test_random_traffic();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (allowed_expected.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, allowed_expected.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pktb_pkg.sv
hdl/pktb_ram.sv
hdl/per_key_token_bucket_limiter_top.sv
sim/per_key_token_bucket_limiter_top_test.sv
